// ----- src/frt_pkg.sv -----
// fragment reassembly table package: word types, status codes, packet action codes
// no dependencies
package frt_pkg;

	localparam int SLOT_COUNT_DEF   = 16;
	localparam int BUFFER_BYTES_DEF = 2048;

	typedef enum logic [2:0] {
		ST_PASSED    = 3'd0,
		ST_HELD      = 3'd1,
		ST_COMPLETED = 3'd2,
		ST_NO_SLOT   = 3'd3,
		ST_NOT_FOUND = 3'd4,
		ST_READ_DATA = 3'd5
	} status_t;

	typedef enum logic [6:0] {
		ACT_IDLE      = 7'b0000001,
		ACT_PASS      = 7'b0000010,
		ACT_HEAD      = 7'b0000100,
		ACT_MORE      = 7'b0001000,
		ACT_NO_SLOT   = 7'b0010000,
		ACT_NOT_FOUND = 7'b0100000,
		ACT_FINAL     = 7'b1000000
	} action_t;

	typedef struct packed {
		logic        operation;
		logic [15:0] ip_id;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic        more_fragments;
		logic [12:0] frag_offset;
		logic [7:0]  data_byte;
		logic        last_byte;
		logic [3:0]  read_slot;
		logic [10:0] read_index;
	} item_t;

	typedef struct packed {
		status_t     status;
		logic [3:0]  slot;
		logic [11:0] total_length;
		logic [7:0]  read_byte;
	} result_t;

	typedef struct packed {
		logic [15:0] ip_id;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
	} key_t;

	typedef struct packed {
		logic has_result;
		logic read_hit;
	} word_info_t;

endpackage

// ----- src/frt_ram.sv -----
// generic single write port, single read port ram with registered read data
// no dependencies
module frt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- src/frt_table.sv -----
// slot table: key match, free slot pick, per-packet action, lengths and byte store
// depends on frt_pkg and frt_ram
module frt_table
	import frt_pkg::*;
#(
	parameter int SLOT_COUNT   = SLOT_COUNT_DEF,
	parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       go,
	input  item_t      item,
	output result_t    res,
	output word_info_t info,
	output logic [7:0] rd_byte
);

	localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int BW = $clog2(BUFFER_BYTES);
	localparam int LW = $clog2(BUFFER_BYTES + 1);
	localparam int CW = (LW > 11) ? LW : 11;
	localparam int AW = $clog2(SLOT_COUNT * BUFFER_BYTES);

	logic [SLOT_COUNT-1:0] in_use_q;
	logic [SLOT_COUNT-1:0] findable_q;
	logic [LW-1:0]         length_q [SLOT_COUNT];
	key_t                  key_q [SLOT_COUNT];
	logic [SW-1:0]         cur_slot_q;
	action_t               action_q;

	key_t                  key_in;
	logic [SLOT_COUNT-1:0] match;
	logic [SW-1:0]         free_idx;
	logic [SW-1:0]         match_idx;
	logic                  any_free;
	logic                  any_match;
	action_t               dec_act;
	logic [SW-1:0]         dec_slot;
	logic                  idle;
	logic                  head_now;
	action_t               eff_act;
	logic [SW-1:0]         eff_slot;
	logic                  storing;
	logic                  is_read;
	logic                  rd_ok;
	logic [SW-1:0]         len_idx;
	logic [LW-1:0]         len_cur;
	logic [LW-1:0]         base_len;
	logic                  room;
	logic [LW-1:0]         new_len;
	logic                  wr_en;
	logic [AW-1:0]         waddr;
	logic                  re;
	logic [AW-1:0]         raddr;

	always_comb begin
		key_in = '{ip_id: item.ip_id, src_addr: item.src_addr, dst_addr: item.dst_addr};
		free_idx  = '0;
		match_idx = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			match[i] = findable_q[i] && (key_q[i] == key_in);
			if (!in_use_q[i]) begin
				free_idx = SW'(i);
			end
			if (match[i]) begin
				match_idx = SW'(i);
			end
		end
		any_free  = ~&in_use_q;
		any_match = |match;

		priority if (item.more_fragments && (item.frag_offset == '0)) begin
			dec_act  = any_free ? ACT_HEAD : ACT_NO_SLOT;
			dec_slot = free_idx;
		end else if (item.frag_offset != '0) begin
			dec_act  = !any_match ? ACT_NOT_FOUND : (item.more_fragments ? ACT_MORE : ACT_FINAL);
			dec_slot = match_idx;
		end else begin
			dec_act  = ACT_PASS;
			dec_slot = cur_slot_q;
		end

		idle     = (action_q == ACT_IDLE);
		eff_act  = idle ? dec_act : action_q;
		eff_slot = (idle && (dec_act == ACT_HEAD || dec_act == ACT_MORE || dec_act == ACT_FINAL))
			? dec_slot : cur_slot_q;
		storing  = (eff_act == ACT_HEAD) || (eff_act == ACT_MORE) || (eff_act == ACT_FINAL);
		is_read  = item.operation;
		head_now = !is_read && idle && (dec_act == ACT_HEAD);

		rd_ok    = 9'(item.read_slot) < 9'(SLOT_COUNT);
		len_idx  = is_read ? SW'(item.read_slot) : eff_slot;
		len_cur  = (is_read && !rd_ok) ? '0 : length_q[len_idx];
		base_len = head_now ? '0 : len_cur;
		room     = base_len < LW'(BUFFER_BYTES);
		new_len  = base_len + LW'(room && storing);

		wr_en = go && !is_read && storing && room;
		waddr = AW'(eff_slot) * AW'(BUFFER_BYTES) + AW'(base_len[BW-1:0]);
		re    = go && is_read;
		raddr = AW'(len_idx) * AW'(BUFFER_BYTES) + AW'(item.read_index);

		info.has_result = is_read || item.last_byte;
		info.read_hit   = is_read && rd_ok && (CW'(item.read_index) < CW'(len_cur));

		res = '{status: ST_PASSED, slot: '0, total_length: '0, read_byte: '0};
		if (is_read) begin
			res.status       = ST_READ_DATA;
			res.slot         = item.read_slot;
			res.total_length = 12'(len_cur);
		end else begin
			unique case (eff_act)
				ACT_HEAD, ACT_MORE: begin
					res.status       = ST_HELD;
					res.slot         = 4'(eff_slot);
					res.total_length = 12'(new_len);
				end
				ACT_FINAL: begin
					res.status       = ST_COMPLETED;
					res.slot         = 4'(eff_slot);
					res.total_length = 12'(new_len);
				end
				ACT_NO_SLOT:   res.status = ST_NO_SLOT;
				ACT_NOT_FOUND: res.status = ST_NOT_FOUND;
				default:       res.status = ST_PASSED;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q   <= '0;
			findable_q <= '0;
			cur_slot_q <= '0;
			action_q   <= ACT_IDLE;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				length_q[i] <= '0;
			end
		end else if (go && !is_read) begin
			if (head_now) begin
				findable_q         <= (findable_q & ~match) | (SLOT_COUNT'(1) << dec_slot);
				in_use_q[dec_slot] <= 1'b1;
			end
			if (storing) begin
				length_q[eff_slot] <= new_len;
			end
			cur_slot_q <= eff_slot;
			if (item.last_byte) begin
				action_q <= ACT_IDLE;
				if (eff_act == ACT_FINAL) begin
					in_use_q[eff_slot]   <= 1'b0;
					findable_q[eff_slot] <= 1'b0;
				end
			end else begin
				action_q <= eff_act;
			end
		end
	end

	// keys are only compared for findable slots
	always_ff @(posedge clk) begin
		if (go && head_now) begin
			key_q[dec_slot] <= key_in;
		end
	end

	frt_ram #(
		.WIDTH(8),
		.DEPTH(SLOT_COUNT * BUFFER_BYTES)
	) u_store (
		.clk  (clk),
		.we   (wr_en),
		.waddr(waddr),
		.wdata(item.data_byte),
		.re   (re),
		.raddr(raddr),
		.rdata(rd_byte)
	);

endmodule

// ----- src/ip_fragment_reassembly_table.sv -----
// IPv4 fragment reassembly table, top level: input register, slot table, result register
// depends on frt_pkg, frt_table and frt_ram
//
// Takes one packet byte or one read request per word and accepts a new word every
// cycle, unless a word with a result waits for the output register to be taken. A
// word is registered on entry and processed from that input register, where the key
// match and free slot pick run in parallel over all SLOT_COUNT slots; its result, if
// any, is registered in the output register. The byte store is a single ram of
// SLOT_COUNT * BUFFER_BYTES bytes with one write port (appends) and one registered
// read port (reads); it is not cleared after reset, and no clearing pass is needed
// since a read only returns bytes below the slot's stored length. Words that produce
// no result keep flowing while a result waits to be taken.
module ip_fragment_reassembly_table
	import frt_pkg::*;
#(
	parameter int SLOT_COUNT   = SLOT_COUNT_DEF,
	parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	item_t      item_s1;
	logic       valid_s1;
	result_t    result_s2;
	logic       hit_s2;
	logic       valid_s2;

	result_t    res;
	word_info_t info;
	logic [7:0] rd_byte;
	logic       s2_free;
	logic       go;

	assign s2_free    = !valid_s2 || result_ready;
	assign go         = valid_s1 && (!info.has_result || s2_free);
	assign item_ready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (item_ready) begin
				valid_s1 <= item_valid;
			end
			if (go && info.has_result) begin
				valid_s2 <= 1'b1;
			end else if (result_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
		if (go && info.has_result) begin
			result_s2 <= res;
			hit_s2    <= info.read_hit;
		end
	end

	frt_table #(
		.SLOT_COUNT  (SLOT_COUNT),
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.item   (item_s1),
		.res    (res),
		.info   (info),
		.rd_byte(rd_byte)
	);

	always_comb begin
		result           = result_s2;
		result.read_byte = hit_s2 ? rd_byte : '0;
	end

	assign result_valid = valid_s2;

endmodule

// ----- tb/ip_fragment_reassembly_table_test.sv -----
`timescale 1ns / 100ps
// testbench for ip_fragment_reassembly_table: queue-fed driver, checking monitor, predictor
// of the slot table, watchdog on stalled handshakes
// depends on frt_pkg and the ip_fragment_reassembly_table top level
module ip_fragment_reassembly_table_test;
	import frt_pkg::*;

	localparam int SLOTS           = SLOT_COUNT_DEF;
	localparam int BUF_BYTES       = BUFFER_BYTES_DEF;
	localparam logic OP_PACKET     = 1'b0;
	localparam logic OP_READ       = 1'b1;
	localparam int RANDOM_WORDS    = 700;
	localparam int IDLE_PCT        = 20;
	localparam int QUIET_FROM      = 150;
	localparam int QUIET_TO        = 450;
	localparam int LONG_STALL_AT   = 600;
	localparam int LONG_STALL_LEN  = 400;
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int DRAIN_CYCLES    = 10;

	typedef struct {
		item_t word;
		bit    drain_first;
	} queued_word_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_ready;
	item_t   item = '0;
	logic    result_valid;
	logic    result_ready = 1'b0;
	result_t result;

	queued_word_t words_to_send[$];
	result_t      status_due[$];
	key_t         open_keys[$];
	result_t      due;
	bit           hold_next;
	int           mid_read_pct;
	int           stimulus_words;
	int           words_accepted;
	int           status_checked;
	int           seen_by_status[8];
	int           failures;
	int           cycle_count = 0;
	int           stall_left;

	// predictor state
	logic        slot_busy[SLOTS];
	logic        slot_visible[SLOTS];
	key_t        slot_owner[SLOTS];
	logic [11:0] slot_fill[SLOTS];
	logic [7:0]  reassembly_buf[SLOTS * BUF_BYTES];
	logic [3:0]  open_slot;
	action_t     packet_mode;

	ip_fragment_reassembly_table DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	function automatic bit idle_this_cycle();
		return ($urandom_range(0, 99) < IDLE_PCT)
			&& !(cycle_count >= QUIET_FROM && cycle_count < QUIET_TO);
	endfunction

	task automatic reassemble_word(input item_t w);
		key_t    k;
		result_t r;
		bit      found;
		k.ip_id    = w.ip_id;
		k.src_addr = w.src_addr;
		k.dst_addr = w.dst_addr;
		r = '0;
		if (w.operation == OP_READ) begin
			r.status       = ST_READ_DATA;
			r.slot         = w.read_slot;
			r.total_length = slot_fill[w.read_slot];
			if (w.read_index < slot_fill[w.read_slot])
				r.read_byte = reassembly_buf[w.read_slot * BUF_BYTES + w.read_index];
			status_due.push_back(r);
		end else begin
			if (packet_mode == ACT_IDLE) begin
				found = 1'b0;
				if (w.more_fragments && w.frag_offset == 0) begin
					packet_mode = ACT_NO_SLOT;
					for (int s = 0; s < SLOTS; s++) begin
						if (!found && !slot_busy[s]) begin
							// newer first fragment hides older slots with the same key
							for (int t = 0; t < SLOTS; t++)
								if (slot_visible[t] && slot_owner[t] == k)
									slot_visible[t] = 1'b0;
							slot_busy[s]    = 1'b1;
							slot_visible[s] = 1'b1;
							slot_owner[s]   = k;
							slot_fill[s]    = '0;
							open_slot       = 4'(s);
							packet_mode     = ACT_HEAD;
							found           = 1'b1;
						end
					end
				end else if (w.frag_offset != 0) begin
					packet_mode = ACT_NOT_FOUND;
					for (int s = 0; s < SLOTS; s++) begin
						if (!found && slot_visible[s] && slot_owner[s] == k) begin
							open_slot   = 4'(s);
							packet_mode = w.more_fragments ? ACT_MORE : ACT_FINAL;
							found       = 1'b1;
						end
					end
				end else begin
					packet_mode = ACT_PASS;
				end
			end
			if (packet_mode inside {ACT_HEAD, ACT_MORE, ACT_FINAL}
				&& slot_fill[open_slot] < BUF_BYTES) begin
				reassembly_buf[open_slot * BUF_BYTES + slot_fill[open_slot]] = w.data_byte;
				slot_fill[open_slot] = 12'(slot_fill[open_slot] + 1);
			end
			if (w.last_byte) begin
				case (packet_mode)
					ACT_HEAD, ACT_MORE: begin
						r.status       = ST_HELD;
						r.slot         = open_slot;
						r.total_length = slot_fill[open_slot];
					end
					ACT_FINAL: begin
						r.status                = ST_COMPLETED;
						r.slot                  = open_slot;
						r.total_length          = slot_fill[open_slot];
						slot_busy[open_slot]    = 1'b0;
						slot_visible[open_slot] = 1'b0;
					end
					ACT_NO_SLOT:   r.status = ST_NO_SLOT;
					ACT_NOT_FOUND: r.status = ST_NOT_FOUND;
					default:       r.status = ST_PASSED;
				endcase
				status_due.push_back(r);
				packet_mode = ACT_IDLE;
			end
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && item_ready) begin
				reassemble_word(item);
				words_accepted++;
			end
			if (!item_valid || item_ready) begin
				if (words_to_send.size() != 0 && words_to_send[0].drain_first
					&& (status_due.size() != 0 || result_valid)) begin
					item_valid <= 1'b0;
				end else if (words_to_send.size() != 0 && !idle_this_cycle()) begin
					item       <= words_to_send[0].word;
					item_valid <= 1'b1;
					words_to_send.pop_front();
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				if (status_due.size() == 0) begin
					$display("%0t: unexpected word, got st %0d slot %0d len %0d byte %0d",
						$time, result.status, result.slot, result.total_length, result.read_byte);
					failures++;
				end else begin
					due = status_due.pop_front();
					status_checked++;
					seen_by_status[int'(due.status)]++;
					if (result.status !== due.status || result.slot !== due.slot
						|| result.total_length !== due.total_length
						|| result.read_byte !== due.read_byte) begin
						$display("%0t: exp st %0d sl %0d len %0d b %0d, got st %0d sl %0d len %0d b %0d",
							$time, due.status, due.slot, due.total_length, due.read_byte,
							result.status, result.slot, result.total_length, result.read_byte);
						failures++;
					end
				end
			end
			if (stall_left != 0) begin
				stall_left--;
				result_ready <= 1'b0;
			end else if (cycle_count == LONG_STALL_AT) begin
				stall_left = LONG_STALL_LEN - 1;
				result_ready <= 1'b0;
			end else begin
				result_ready <= !idle_this_cycle();
			end
		end
	end

	function automatic item_t random_word();
		logic [127:0] bits;
		bits = {$urandom, $urandom, $urandom, $urandom};
		return bits[$bits(item_t)-1:0];
	endfunction

	function automatic key_t fresh_key();
		key_t k;
		k.ip_id    = 16'($urandom_range(0, 65535));
		k.src_addr = $urandom;
		k.dst_addr = $urandom;
		return k;
	endfunction

	task automatic push_word(input item_t w);
		words_to_send.push_back('{word: w, drain_first: hold_next});
		hold_next = 1'b0;
		stimulus_words++;
	endtask

	task automatic add_read(input logic [3:0] s, input logic [10:0] idx);
		item_t w;
		w            = random_word();
		w.operation  = OP_READ;
		w.read_slot  = s;
		w.read_index = idx;
		push_word(w);
	endtask

	task automatic add_packet(input key_t k, input logic mf, input logic [12:0] off,
		input int nbytes);
		item_t w;
		for (int i = 0; i < nbytes; i++) begin
			if (i != 0 && $urandom_range(0, 99) < mid_read_pct)
				add_read(4'($urandom_range(0, 15)), 11'($urandom_range(0, 15)));
			w           = random_word();
			w.operation = OP_PACKET;
			w.last_byte = (i == nbytes - 1);
			if (i == 0) begin
				w.ip_id          = k.ip_id;
				w.src_addr       = k.src_addr;
				w.dst_addr       = k.dst_addr;
				w.more_fragments = mf;
				w.frag_offset    = off;
			end
			push_word(w);
		end
	endtask

	function automatic int packet_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
	endfunction

	initial begin
		key_t k_zero;
		key_t k_ones;
		key_t k_near;
		key_t k;
		int   choice;
		int   idx;
		int   leaked_slots;
		bit   burst_done;

		for (int s = 0; s < SLOTS; s++) begin
			slot_busy[s]    = 1'b0;
			slot_visible[s] = 1'b0;
			slot_fill[s]    = '0;
		end
		open_slot   = '0;
		packet_mode = ACT_IDLE;

		// directed
		mid_read_pct = 50;
		k_zero = '0;
		k_ones = '1;
		k_near = k_zero;
		k_near.ip_id = 16'h0001;
		add_read(4'd0, 11'd0);
		add_packet(k_ones, 1'b0, 13'd0, 2);
		add_packet(k_zero, 1'b1, 13'd0, 2);
		add_read(4'd0, 11'd1);
		add_read(4'd0, 11'd2);
		add_read(4'd15, 11'd2047);
		add_packet(k_zero, 1'b1, 13'd1, 2);
		add_packet(k_near, 1'b0, 13'h1fff, 1);
		add_packet(k_ones, 1'b1, 13'd0, 1);
		add_packet(k_zero, 1'b1, 13'd0, 1);
		add_packet(k_zero, 1'b0, 13'h1fff, 1);
		add_read(4'd2, 11'd1);
		add_packet(k_zero, 1'b0, 13'd2, 1);
		add_packet(k_ones, 1'b0, 13'h1000, 2);
		add_read(4'd1, 11'd2);

		// random datagram traffic with noise
		mid_read_pct = 10;
		leaked_slots = 1;
		burst_done   = 1'b0;
		hold_next    = 1'b1;
		while (stimulus_words < RANDOM_WORDS) begin
			if (!burst_done && stimulus_words >= 400) begin
				// fill the table, one start too many, then close every open key
				burst_done = 1'b1;
				while (open_keys.size() + leaked_slots < SLOTS) begin
					k = fresh_key();
					add_packet(k, 1'b1, 13'd0, 1);
					open_keys.push_back(k);
				end
				add_packet(fresh_key(), 1'b1, 13'd0, 2);
				while (open_keys.size() != 0)
					add_packet(open_keys.pop_front(), 1'b0, 13'($urandom_range(1, 8191)),
						$urandom_range(1, 2));
			end
			choice = $urandom_range(0, 99);
			if ($urandom_range(0, 99) == 0)
				hold_next = 1'b1;
			if (choice < 8) begin
				add_read(4'($urandom_range(0, 15)), ($urandom_range(0, 9) < 6)
					? 11'($urandom_range(0, 15)) : 11'($urandom_range(0, 2047)));
			end else if ((choice < 35 || open_keys.size() == 0) && open_keys.size() < 12) begin
				k = fresh_key();
				if (open_keys.size() + leaked_slots < SLOTS)
					open_keys.push_back(k);
				add_packet(k, 1'b1, 13'd0, packet_len());
			end else if (choice < 60 && open_keys.size() != 0) begin
				idx = $urandom_range(0, open_keys.size() - 1);
				add_packet(open_keys[idx], 1'b1, 13'($urandom_range(1, 8191)), packet_len());
			end else if (choice < 88 && open_keys.size() != 0) begin
				idx = $urandom_range(0, open_keys.size() - 1);
				add_packet(open_keys[idx], 1'b0, 13'($urandom_range(1, 8191)), packet_len());
				open_keys.delete(idx);
			end else if (choice < 93) begin
				add_packet(fresh_key(), 1'b0, 13'd0, packet_len());
			end else if (choice < 97) begin
				add_packet(fresh_key(), 1'($urandom_range(0, 1)),
					13'($urandom_range(1, 8191)), packet_len());
			end else if (leaked_slots < 4 && open_keys.size() != 0
				&& open_keys.size() + leaked_slots < SLOTS) begin
				idx = $urandom_range(0, open_keys.size() - 1);
				add_packet(open_keys[idx], 1'b1, 13'd0, packet_len());
				leaked_slots++;
			end else begin
				add_read(4'($urandom_range(0, 15)), 11'($urandom_range(0, 2047)));
			end
		end
		while (open_keys.size() != 0)
			add_packet(open_keys.pop_front(), 1'b0, 13'($urandom_range(1, 8191)), 1);

		// one long datagram in two fragments, then read every slot
		mid_read_pct = 2;
		hold_next    = 1'b1;
		k = fresh_key();
		add_packet(k, 1'b1, 13'd0, 60);
		add_packet(k, 1'b0, 13'($urandom_range(1, 8191)), 50);
		for (int s = 0; s < SLOTS; s++) begin
			add_read(4'(s), 11'd2047);
			add_read(4'(s), 11'($urandom_range(0, 127)));
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (words_to_send.size() != 0 || item_valid)
			@(posedge clk);
		while (status_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d words accepted, %0d status words checked, %0d reads",
			words_accepted, status_checked, seen_by_status[int'(ST_READ_DATA)]);
		$display("completed %0d, held %0d, no free slot %0d, not found %0d, passed %0d",
			seen_by_status[int'(ST_COMPLETED)], seen_by_status[int'(ST_HELD)],
			seen_by_status[int'(ST_NO_SLOT)], seen_by_status[int'(ST_NOT_FOUND)],
			seen_by_status[int'(ST_PASSED)]);
		if (failures == 0) begin
			$display("ip_fragment_reassembly_table test passed");
		end else begin
			$display("ip_fragment_reassembly_table test failed");
		end
		$finish;
	end

	// watchdog
	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (item_valid && item_ready) || (result_valid && result_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("ip_fragment_reassembly_table test failed");
		$finish;
	end

endmodule

// ----- ip_fragment_reassembly_table.f -----
src/frt_pkg.sv
src/frt_ram.sv
src/frt_table.sv
src/ip_fragment_reassembly_table.sv
tb/ip_fragment_reassembly_table_test.sv
